@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every clock edge outside reset.
`define CHK_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/ppsjm_pkg.sv @@
// Package for the pulse period and jitter monitor: widths, codes, command types.
// No dependencies.
`default_nettype none
package ppsjm_pkg;
  localparam int RING_DEPTH = 64;
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int CNT_W = RING_AW + 1;
  localparam logic [31:0] NOMINAL_RST = 32'd1000000;
  localparam logic [19:0] TOL_RST = 20'd100;
  localparam logic [31:0] PRES_RST = 32'd2000000;
  localparam logic [31:0] MIN_EDGES = 32'd3;
  localparam logic [31:0] SD_LIMIT = 32'd2147483;
  localparam logic [31:0] JIT_NONE = 32'hFFFF_FFFF;
  localparam logic [31:0] JIT_SAT = 32'h7FFF_FFFF;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_NOMINAL = 2'd0;
  localparam logic [1:0] REG_TOL = 2'd1;
  localparam logic [1:0] REG_PRES = 2'd2;

  typedef struct packed {
    logic clr_scan;   // clear accumulators and scan counter
    logic rd_ring;    // read ring pair at scan index
    logic acc_sum;    // accumulate period sum
    logic acc_sq;     // accumulate squared deviation
    logic div_start;  // start a 64/CNT divide
    logic div_var;    // 0: mean divide, 1: variance divide
    logic sqrt_start; // start the root iteration
    logic sqrt_step;  // one root step, two radicand bits
    logic mul_start;  // scale root by 1000
    logic do_edge;    // apply an edge item
    logic do_query;   // capture query scalars
    logic finish;     // present the result
  } ppsjm_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_busy;
    logic sqrt_done;
    logic too_few;
    logic enough_edges;
  } ppsjm_sts_t;
endpackage
`default_nettype wire

@@ rtl/pps_period_jitter_monitor.sv @@
// Channel  | Dir | Payload
// s_axis   | in  | tuser=opcode, tdata={timer_cycles,time_us}
// m_axis   | out | tdata = result fields, lowest first, zero padded to 328 bits
// cfg      | in  | cfg_we, cfg_index, cfg_data
// An edge request goes from acceptance through S_DONE to the result register. A query
// with n = min(RING_DEPTH-1, edges-1) runs two ring scans of n entries, two divides
// and a 32-step root; with too little data it finishes after the first scan.
// One request at a time; a new request is taken while a result waits in the output
// register, and a finished result waits in the controller until that register frees.
// rst is synchronous and clears the edge, good and bad counters and the ring valid flags.
// Top level of the pulse period and jitter monitor; uses ppsjm_pkg, ppsjm_ctrl,
// ppsjm_datapath.
`default_nettype none
module pps_period_jitter_monitor (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [95:0]  s_axis_tdata,  // time_us, timer_cycles
  input  wire logic         s_axis_tuser,  // opcode
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pulse_valid, edge_total, valid_total, invalid_total, period_error_ns,
  // last_edge_us, last_edge_cycles, signal_present, age_us, jitter_ns
  output logic [327:0]      m_axis_tdata
);
  import ppsjm_pkg::*;
  ppsjm_cmd_t cmd;
  ppsjm_sts_t sts;
  logic is_query;
  logic [320:0] res;
  logic pv_calc;
  logic [31:0] good_prev;

  ppsjm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_op(s_axis_tuser),
    .in_ready(s_axis_tready), .out_free(!m_axis_tvalid || m_axis_tready),
    .is_query(is_query), .cmd(cmd), .sts(sts)
  );
  ppsjm_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_time(s_axis_tdata[63:0]), .in_cycles(s_axis_tdata[95:64]), .cmd(cmd),
    .sts(sts), .res_data(res)
  );

  // An edge was in the window when the good counter moved.
  always_ff @(posedge clk) begin
    if (cmd.do_edge) good_prev <= res[63:32];
  end
  assign pv_calc = !is_query && (res[63:32] != good_prev);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.finish) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
    if (cmd.finish) begin
      m_axis_tdata[0] <= pv_calc;
      m_axis_tdata[192:1] <= res[191:0];
      m_axis_tdata[224:193] <= res[223:192];
      m_axis_tdata[225] <= is_query ? res[224] : 1'b0;
      m_axis_tdata[289:226] <= is_query ? res[288:225] : 64'd0;
      m_axis_tdata[321:290] <= is_query ? res[320:289] : 32'd0;
      m_axis_tdata[327:322] <= 6'd0;
    end
  end
endmodule
`default_nettype wire

@@ rtl/ppsjm_div.sv @@
// Restoring divider, 64-bit dividend by a small unsigned divisor, one bit per cycle.
// Uses ppsjm_pkg.
`default_nettype none
module ppsjm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             busy,
  output logic [63:0]      quotient
);
  import ppsjm_pkg::*;
  logic [63:0] rem;
  logic [63:0] quo;
  logic [6:0]  step;
  logic [64:0] trial;
  logic [63:0] rem_sh;

  assign rem_sh = {rem[62:0], quo[63]};
  assign trial = {1'b0, rem_sh} - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= 7'd64;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (trial[64]) begin
        rem <= rem_sh;
        quo <= {quo[62:0], 1'b0};
      end else begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b1};
      end
      step <= step - 7'd1;
      if (step == 7'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ rtl/ppsjm_datapath.sv @@
// Datapath: configuration, edge state, timestamp ring, jitter arithmetic.
// Uses ppsjm_pkg and ppsjm_div.
`default_nettype none
module ppsjm_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic [63:0]            in_time,
  input  wire logic [31:0]            in_cycles,
  input  wire ppsjm_pkg::ppsjm_cmd_t  cmd,
  output ppsjm_pkg::ppsjm_sts_t       sts,
  output logic [320:0]                res_data
);
  import ppsjm_pkg::*;

  logic [31:0] nominal, pres_win;
  logic [19:0] tol;
  logic [63:0] last_time;
  logic [31:0] last_cycles, edges, good, bad, err_ns;
  logic [63:0] ring [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld;
  logic [RING_AW-1:0] head;
  logic [CNT_W-1:0] scan_i;
  logic [CNT_W-1:0] pcnt;
  logic [63:0] ra, rb;
  logic        ra_v, rb_v, rd_ok;
  logic [63:0] sum, sq, mean, var_q, root;
  logic        present, jit_none;
  logic [63:0] age;
  logic [31:0] jit;
  logic        div_start;
  logic [63:0] div_a, div_q;
  logic        div_busy;
  logic [63:0] diff, per_d;
  logic [63:0] sq_p0;
  logic [31:0] sq_p1;
  logic        sq_v;
  logic [32:0] lo_w, hi_w;
  logic [63:0] period;
  logic [63:0] scaled;
  logic [RING_AW-1:0] ia, ib;

  assign period = in_time - last_time;
  assign lo_w = ({12'd0, tol} < nominal) ? {1'b0, nominal - {12'd0, tol}} : 33'd0;
  assign hi_w = {1'b0, nominal} + {13'd0, tol};
  assign ia = head - scan_i[RING_AW-1:0];
  assign ib = ia - RING_AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal <= NOMINAL_RST;
      tol <= TOL_RST;
      pres_win <= PRES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NOMINAL: nominal <= cfg_data;
        REG_TOL:     tol <= cfg_data[19:0];
        REG_PRES:    pres_win <= cfg_data;
        default: ;
      endcase
    end
  end

  // Ring storage; an entry not yet written is marked invalid in ring_vld.
  always_ff @(posedge clk) begin
    if (cmd.do_edge) ring[head] <= in_time;
    if (cmd.rd_ring) begin
      ra <= ring[ia];
      rb <= ring[ib];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
      head <= '0;
      last_time <= '0;
      last_cycles <= '0;
      edges <= '0;
      good <= '0;
      bad <= '0;
      err_ns <= '0;
      ra_v <= 1'b0;
      rb_v <= 1'b0;
    end else begin
      if (cmd.rd_ring) begin
        ra_v <= ring_vld[ia];
        rb_v <= ring_vld[ib];
      end
      if (cmd.do_edge) begin
        if (edges != 32'd0) begin
          if ({1'b0, period} >= {32'd0, lo_w} && {1'b0, period} <= {32'd0, hi_w}) begin
            good <= good + 32'd1;
            err_ns <= 32'(period - {32'd0, nominal}) * 32'd1000;
          end else begin
            bad <= bad + 32'd1;
          end
        end
        last_time <= in_time;
        last_cycles <= in_cycles;
        edges <= edges + 32'd1;
        ring_vld[head] <= 1'b1;
        head <= head + RING_AW'(1);
      end
    end
  end

  assign rd_ok = ra_v && rb_v && ra != 64'd0 && rb != 64'd0;
  assign diff = ra - rb;
  assign per_d = diff - mean;

  // Scan passes: index 1 .. min(RING_DEPTH-1, edges-1). A read lands in the cycle after.
  // The square modulo 2^64 is built from two 32-bit products registered in the cycle after that.
  logic acc_pend;
  always_ff @(posedge clk) begin
    if (cmd.clr_scan) begin
      scan_i <= CNT_W'(1);
      acc_pend <= 1'b0;
      sq_v <= 1'b0;
      if (!cmd.acc_sq) begin
        sum <= '0;
        pcnt <= '0;
      end
      sq <= '0;
    end else begin
      acc_pend <= cmd.rd_ring;
      sq_v <= acc_pend && rd_ok && cmd.acc_sq;
      if (cmd.rd_ring) scan_i <= scan_i + CNT_W'(1);
      if (acc_pend && rd_ok && cmd.acc_sum) begin
        sum <= sum + diff;
        pcnt <= pcnt + CNT_W'(1);
      end
      if (sq_v) sq <= sq + sq_p0 + {sq_p1[30:0], 33'd0};
    end
    sq_p0 <= per_d[31:0] * per_d[31:0];
    sq_p1 <= per_d[63:32] * per_d[31:0];
  end

  assign sts.scan_done = (scan_i >= CNT_W'(RING_DEPTH)) ||
                         ({{(32-CNT_W){1'b0}}, scan_i} >= edges);
  assign sts.too_few = pcnt < CNT_W'(2);
  assign sts.enough_edges = edges >= MIN_EDGES;

  // Mean uses a signed sum: divide the magnitude and restore the sign.
  logic sum_neg;
  assign sum_neg = sum[63];
  assign div_a = cmd.div_var ? sq : (sum_neg ? (~sum + 64'd1) : sum);
  assign div_start = cmd.div_start;

  ppsjm_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a),
    .divisor({{(64-CNT_W){1'b0}}, pcnt}), .busy(div_busy), .quotient(div_q)
  );
  assign sts.div_busy = div_busy;

  logic div_var_q;
  logic div_was_busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      div_was_busy <= 1'b0;
    end else begin
      div_was_busy <= div_busy;
    end
    if (div_start) div_var_q <= cmd.div_var;
    if (div_was_busy && !div_busy) begin
      if (div_var_q) var_q <= div_q;
      else mean <= sum_neg ? (~div_q + 64'd1) : div_q;
    end
  end

  // Integer square root, two bits of the radicand per step, 32 steps.
  // It gives the floor of the root, as the Newton iteration does.
  logic [63:0] rt_op, rt_bit, rt_res, rt_try;
  assign rt_try = rt_res + rt_bit;
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rt_op <= var_q;
      rt_res <= '0;
      rt_bit <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step && rt_bit != 64'd0) begin
      if (rt_op >= rt_try) begin
        rt_op <= rt_op - rt_try;
        rt_res <= (rt_res >> 1) + rt_bit;
      end else begin
        rt_res <= rt_res >> 1;
      end
      rt_bit <= rt_bit >> 2;
    end
  end
  assign root = rt_res;
  assign sts.sqrt_done = rt_bit == 64'd0;

  always_ff @(posedge clk) begin
    if (cmd.mul_start) scaled <= root * 64'd1000;
  end

  always_ff @(posedge clk) begin
    if (cmd.do_query) begin
      present <= (last_time != 64'd0) && ((in_time - last_time) < {32'd0, pres_win});
      age <= (last_time != 64'd0 && in_time >= last_time) ? in_time - last_time : 64'd0;
    end
  end

  assign jit_none = !sts.enough_edges || sts.too_few;
  always_comb begin
    if (jit_none) jit = JIT_NONE;
    else if (root > {32'd0, SD_LIMIT}) jit = JIT_SAT;
    else if (scaled > {32'd0, JIT_SAT}) jit = JIT_SAT;
    else jit = scaled[31:0];
  end

  assign res_data = {jit, age, present, last_cycles, last_time, err_ns, bad, good, edges};
endmodule
`default_nettype wire

@@ rtl/ppsjm_ctrl.sv @@
// Controller sequencing edges, queries and the jitter computation.
// Uses ppsjm_pkg.
`default_nettype none
module ppsjm_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_op,
  output logic                       in_ready,
  input  wire logic                  out_free,
  output logic                       is_query,
  output ppsjm_pkg::ppsjm_cmd_t      cmd,
  input  wire ppsjm_pkg::ppsjm_sts_t sts
);
  import ppsjm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_SCAN1 = 10'b0000000010, S_MEAN = 10'b0000000100,
    S_MWAIT = 10'b0000001000, S_SCAN2 = 10'b0000010000, S_VAR = 10'b0000100000,
    S_VWAIT = 10'b0001000000, S_ROOT = 10'b0010000000, S_MUL = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic [1:0] wcnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        if (in_op == OP_EDGE) begin
          cmd.do_edge = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.do_query = 1'b1;
          cmd.clr_scan = 1'b1;
          state_next = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cmd.acc_sum = 1'b1;
        if (!sts.scan_done) cmd.rd_ring = 1'b1;
        else if (wcnt == 2'd1) state_next = S_MEAN;
      end
      S_MEAN: begin
        if (!sts.enough_edges || sts.too_few) state_next = S_DONE;
        else begin
          cmd.div_start = 1'b1;
          state_next = S_MWAIT;
        end
      end
      S_MWAIT: if (!sts.div_busy && wcnt == 2'd2) begin
        cmd.clr_scan = 1'b1;
        cmd.acc_sq = 1'b1;
        state_next = S_SCAN2;
      end
      S_SCAN2: begin
        cmd.acc_sq = 1'b1;
        if (!sts.scan_done) cmd.rd_ring = 1'b1;
        else if (wcnt == 2'd1) state_next = S_VAR;
      end
      S_VAR: begin
        cmd.div_start = 1'b1;
        cmd.div_var = 1'b1;
        state_next = S_VWAIT;
      end
      S_VWAIT: if (!sts.div_busy && wcnt == 2'd2) begin
        cmd.sqrt_start = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next = S_DONE;
      end
      // The result is handed over once the output register is free.
      S_DONE: if (out_free) begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // wcnt counts the cycles since the last ring read, divider step or state change, and saturates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wcnt <= '0;
      is_query <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state || cmd.rd_ring || sts.div_busy) wcnt <= '0;
      else if (wcnt != 2'd3) wcnt <= wcnt + 2'd1;
      if (state == S_IDLE && in_valid && in_ready) is_query <= in_op;
    end
  end
endmodule
`default_nettype wire

@@ rtl/ppsjm_checker.sv @@
// Port-level checker for the monitor, bound to the top level.
// Uses assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ppsjm_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [327:0] m_axis_tdata
);
  `CHK_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `CHK_NEXT(a_data_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while waiting")
  `CHK_IMPL(a_pad_zero, clk, rst, m_axis_tvalid, m_axis_tdata[327:322] == 6'd0, "padding bits not zero")
  `CHK_NEXT(a_busy_after, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "two requests back to back")
endmodule
bind pps_period_jitter_monitor ppsjm_checker u_chk (.*);
`default_nettype wire

@@ tb/pps_monitor_checker.sv @@
// Checker for the pulse period and jitter monitor: watches the request and result
// streams and the register port, predicts each result and compares it field by field.
// Depends on ppsjm_pkg.
`timescale 1ns / 100ps
module pps_monitor_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [327:0] m_axis_tdata,
  output int           fail_count,
  output int           pending
);
  import ppsjm_pkg::*;

  logic [31:0] nominal;
  logic [19:0] tolerance;
  logic [31:0] pres_window;
  logic [63:0] last_time;
  logic [31:0] last_cycles;
  logic [31:0] edges;
  logic [31:0] good;
  logic [31:0] bad;
  logic [31:0] err_ns;
  logic [63:0] ring [RING_DEPTH];
  int          head;

  logic [321:0] expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] x, y;
    if (v == 0) return 0;
    x = v;
    y = (x >> 1) + x[0];
    while (y < x) begin
      x = y;
      y = (x + v / x) >> 1;
    end
    return x;
  endfunction

  function automatic logic [31:0] jitter_of_ring();
    logic [63:0] per [RING_DEPTH];
    int cnt, a, b;
    logic [63:0] sum, sq, d, sd;
    longint mean;
    cnt = 0;
    sum = 0;
    sq = 0;
    if (edges < MIN_EDGES) return JIT_NONE;
    for (int i = 1; i < RING_DEPTH && i < edges; i++) begin
      a = (head + RING_DEPTH - i) % RING_DEPTH;
      b = (a + RING_DEPTH - 1) % RING_DEPTH;
      if (ring[a] != 0 && ring[b] != 0) begin
        per[cnt] = ring[a] - ring[b];
        cnt++;
      end
    end
    if (cnt < 2) return JIT_NONE;
    for (int k = 0; k < cnt; k++) sum += per[k];
    mean = $signed(sum) / longint'(cnt);
    for (int k = 0; k < cnt; k++) begin
      d = per[k] - 64'(mean);
      sq += d * d;
    end
    sd = isqrt(sq / 64'(cnt));
    if (sd > 64'(SD_LIMIT)) return JIT_SAT;
    sd = sd * 1000;
    if (sd > 64'h7FFF_FFFF) return JIT_SAT;
    return sd[31:0];
  endfunction

  task automatic predict_result(input logic op, input logic [63:0] t, input logic [31:0] cyc);
    logic valid, present;
    logic [63:0] age, period, lo, hi;
    logic [31:0] jit;
    valid = 0;
    present = 0;
    age = 0;
    jit = 0;
    if (op == OP_EDGE) begin
      if (edges != 0) begin
        period = t - last_time;
        lo = nominal > tolerance ? 64'(nominal - tolerance) : 64'd0;
        hi = 64'(nominal) + 64'(tolerance);
        if (period >= lo && period <= hi) begin
          valid = 1;
          good++;
          err_ns = 32'((period - 64'(nominal)) * 1000);
        end else begin
          bad++;
        end
      end
      last_time = t;
      last_cycles = cyc;
      edges++;
      ring[head] = t;
      head = (head + 1) % RING_DEPTH;
    end else begin
      if (last_time != 0) begin
        present = (t - last_time) < 64'(pres_window);
        if (t >= last_time) age = t - last_time;
      end
      jit = jitter_of_ring();
    end
    expected_results.push_back({jit, age, present, last_cycles, last_time, err_ns, bad, good,
                                edges, valid});
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    logic [321:0] e;
    if (rst) begin
      nominal <= NOMINAL_RST;
      tolerance <= TOL_RST;
      pres_window <= PRES_RST;
      last_time = 0;
      last_cycles = 0;
      edges = 0;
      good = 0;
      bad = 0;
      err_ns = 0;
      head = 0;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NOMINAL: nominal <= cfg_data;
          REG_TOL: tolerance <= cfg_data[19:0];
          REG_PRES: pres_window <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_result(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[95:64]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no expectation waiting");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("pulse_valid", e[0], m_axis_tdata[0]);
          check_field("edge_total", e[32:1], m_axis_tdata[32:1]);
          check_field("valid_total", e[64:33], m_axis_tdata[64:33]);
          check_field("invalid_total", e[96:65], m_axis_tdata[96:65]);
          check_field("period_error_ns", e[128:97], m_axis_tdata[128:97]);
          check_field("last_edge_us", e[192:129], m_axis_tdata[192:129]);
          check_field("last_edge_cycles", e[224:193], m_axis_tdata[224:193]);
          check_field("signal_present", e[225], m_axis_tdata[225]);
          check_field("age_us", e[289:226], m_axis_tdata[289:226]);
          check_field("jitter_ns", e[321:290], m_axis_tdata[321:290]);
        end
      end
    end
  end
endmodule

@@ tb/testbench.sv @@
// Top of the monitor testbench: clock, reset, register writes, request stimulus and
// result backpressure. Depends on ppsjm_pkg, pps_monitor_checker and the block.
`timescale 1ns / 100ps
module testbench;
  import ppsjm_pkg::*;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [327:0] m_axis_tdata;
  int           fail_count;
  int           pending;
  int           idle_cycles;
  int           hold_off;
  logic [63:0]  pulse_time;
  logic [31:0]  cur_nominal;

  localparam int WATCHDOG_LIMIT = 20000;

  pps_period_jitter_monitor dut (.*);

  pps_monitor_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls per result, plus one long hold-off.
  initial begin
    m_axis_tready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        m_axis_tready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      repeat ($urandom_range(0, 4)) begin
        m_axis_tready <= 0;
        @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The block is never ready in the cycle after an acceptance, so the idle
  // cycle at the end costs no throughput.
  task automatic send_request(input logic op, input logic [63:0] t, input logic [31:0] cyc,
                              input bit gaps);
    if (gaps)
      repeat ($urandom_range(0, 4)) @(posedge clk);
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {cyc, t};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    s_axis_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain_and_write(input logic [1:0] idx, input logic [31:0] val);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_NOMINAL) cur_nominal = val;
  endtask

  task automatic pulse(input int jit_range, input bit gaps);
    int dev;
    logic [63:0] step;
    dev = $urandom_range(0, 2 * jit_range) - jit_range;
    step = 64'(cur_nominal) + 64'(longint'(dev));
    if ($urandom_range(0, 15) == 0) step = {$urandom, $urandom};
    pulse_time = pulse_time + step;
    send_request(OP_EDGE, pulse_time, $urandom, gaps);
  endtask

  task automatic query(input bit gaps);
    logic [63:0] t;
    case ($urandom_range(0, 5))
      0: t = {$urandom, $urandom};
      1: t = pulse_time - $urandom_range(0, 100);
      default: t = pulse_time + $urandom_range(0, 3000000);
    endcase
    send_request(OP_QUERY, t, $urandom, gaps);
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_NOMINAL;
    cfg_data = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = OP_EDGE;
    hold_off = 0;
    idle_cycles = 0;
    cur_nominal = NOMINAL_RST;
    pulse_time = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: query with no edges, edge at time zero, extremes of the fields.
    send_request(OP_QUERY, 64'd0, 32'd0, 0);
    send_request(OP_EDGE, 64'd0, 32'hFFFF_FFFF, 0);
    send_request(OP_QUERY, 64'd5, 32'd0, 0);
    send_request(OP_EDGE, 64'd1000000, 32'd0, 0);
    send_request(OP_EDGE, 64'd2000100, 32'h1234_5678, 0);
    send_request(OP_EDGE, 64'd2999900, 32'd1, 0);
    send_request(OP_EDGE, 64'd4000000, 32'd2, 0);
    send_request(OP_QUERY, 64'd4000500, 32'd0, 0);
    send_request(OP_QUERY, 64'd3000000, 32'd0, 0);
    send_request(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_request(OP_EDGE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_request(OP_EDGE, 64'h7FFF_FFFF_0000_0000, 32'd0, 0);
    send_request(OP_QUERY, 64'h7FFF_FFFF_0000_0001, 32'd0, 0);

    // Tolerance wider than nominal clamps the lower bound at zero.
    drain_and_write(REG_NOMINAL, 32'd50);
    drain_and_write(REG_TOL, 32'hFFFFF);
    drain_and_write(REG_PRES, 32'hFFFF_FFFF);
    pulse_time = 64'h7FFF_FFFF_0000_0000;
    for (int i = 0; i < 8; i++) pulse(100, 0);
    query(0);
    drain_and_write(REG_NOMINAL, 32'hFFFF_FFFF);
    drain_and_write(REG_TOL, 32'd0);
    drain_and_write(REG_PRES, 32'd1);
    for (int i = 0; i < 4; i++) pulse(1, 0);
    query(0);

    // Random phases with varied settings.
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_write(REG_NOMINAL, (ph % 3 == 0) ? 32'd1000000 : $urandom_range(1, 5000000));
      drain_and_write(REG_TOL, (ph == 5) ? 32'd0 : $urandom_range(0, 2000));
      drain_and_write(REG_PRES, $urandom_range(1, 4000000));
      if (ph == 2) hold_off = 400;
      for (int i = 0; i < 45; i++) begin
        if ($urandom_range(0, 2) == 0) query(ph != 3);
        else pulse($urandom_range(0, 3000), ph != 3);
      end
      if (ph == 4) begin
        // Sender pause until every result is back.
        while (pending != 0) @(posedge clk);
      end
    end

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

@@ pps_period_jitter_monitor.f @@
+incdir+rtl
rtl/ppsjm_pkg.sv
rtl/ppsjm_div.sv
rtl/ppsjm_datapath.sv
rtl/ppsjm_ctrl.sv
rtl/pps_period_jitter_monitor.sv
rtl/ppsjm_checker.sv
tb/pps_monitor_checker.sv
tb/testbench.sv
